FILE: rtl/jdrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job dispatch reorder table: shared package
// Sizes, codes and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jdrt_pkg;

	localparam int JOB_SLOTS   = 16;
	localparam int SLOT_W      = $clog2(JOB_SLOTS);
	localparam int FILL_W      = $clog2(JOB_SLOTS + 1);
	localparam int MAX_WORKERS = 16;
	localparam int WID_W       = $clog2(MAX_WORKERS);
	localparam int WCNT_W      = $clog2(MAX_WORKERS + 1);
	localparam int STAMP_BITS  = 32;
	localparam int MAX_RESULTS = 16;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int LIM_W       = 4;

	localparam logic [31:0]       START_TICK_RST = 32'd50;
	localparam logic [WCNT_W-1:0] WORKERS_RST    = WCNT_W'(3);
	localparam logic [LIM_W-1:0]  LIMIT_RST      = LIM_W'(14);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_TICK = 2'd0,
		REG_WORKERS    = 2'd1,
		REG_LIMIT      = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_JOIN     = 3'd2,
		OP_RETURN   = 3'd3,
		OP_RETRIEVE = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		JS_EMPTY     = 4'd0,
		JS_WAIT      = 4'd1,
		JS_SENT      = 4'd2,
		JS_BUF       = 4'd3,
		JS_JOINED    = 4'd4,
		JS_DEL       = 4'd5,
		JS_SENT_DEL  = 4'd6,
		JS_SENT_JOIN = 4'd7
	} job_state_t;

	typedef enum logic [2:0] {
		K_DONE      = 3'd0,
		K_DISPATCH  = 3'd1,
		K_RETRIEVED = 3'd2,
		K_NOTREADY  = 3'd3,
		K_ERROR     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE      = 2'd0,
		E_NOT_FOUND = 2'd1,
		E_STATE     = 2'd2,
		E_FULL      = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CLS_WAIT   = 2'd0,
		CLS_JOINED = 2'd1,
		CLS_BUF    = 2'd2
	} class_t;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_REQ  = 2'd1,
		SRC_SLOT = 2'd2
	} stamp_src_t;

	typedef enum logic [1:0] {
		SEL_HEAD = 2'd0,
		SEL_LOOK = 2'd1,
		SEL_IDX  = 2'd2,
		SEL_DISP = 2'd3
	} sel_t;

	typedef enum logic [2:0] {
		C_IDLE   = 3'd0,
		C_DECODE = 3'd1,
		C_LOOK   = 3'd2,
		C_APPLY  = 3'd3,
		C_SCAN   = 3'd4,
		C_RET    = 3'd5
	} ctrl_state_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		err_t       err;
		stamp_src_t src;
		logic       last;
	} emit_t;

	typedef struct packed {
		logic  latch;
		sel_t  sel;
		logic  insert;
		logic  look_clear;
		logic  look_next;
		logic  idx_cap;
		logic  apply;
		logic  push;
		logic  scan_clear;
		logic  dispatch;
		logic  skip;
		logic  pop;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		op_t        mode;
		logic       full;
		logic       empty;
		logic       below_head;
		logic       look_end;
		logic       look_hit;
		logic       next_bad;
		logic       scan_end;
		logic       disp_ok;
		logic       free_empty;
		logic       ret_ok;
		job_state_t slot_state;
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/jdrt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job dispatch reorder table: controller
// Sequences decode, stamp lookup, state update, dispatch scan and retrieve.
// ----------------------------------------------------------------------------
module jdrt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire jdrt_pkg::status_t st,
	output jdrt_pkg::cmd_t        cmd
);
	import jdrt_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (start) state_nx = C_DECODE;
			end
			C_DECODE: begin
				case (st.mode)
					OP_INSERT:         state_nx = st.full ? C_IDLE : C_SCAN;
					OP_DELETE, OP_JOIN: state_nx = (st.empty || st.below_head) ? C_IDLE : C_LOOK;
					OP_RETURN:         state_nx = C_LOOK;
					OP_RETRIEVE:       state_nx = C_RET;
					default:           state_nx = C_IDLE;
				endcase
			end
			C_LOOK: begin
				if (st.look_end) state_nx = C_IDLE;
				else if (st.look_hit) state_nx = C_APPLY;
			end
			C_APPLY: begin
				if (st.next_bad || st.mode != OP_RETURN) state_nx = C_IDLE;
				else state_nx = C_SCAN;
			end
			C_SCAN: begin
				if (st.scan_end || (st.disp_ok && st.free_empty)) state_nx = C_IDLE;
			end
			C_RET: begin
				if (!st.ret_ok || st.slot_state != JS_DEL) state_nx = C_IDLE;
			end
			default: state_nx = C_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd     = '0;
		cmd.sel = SEL_HEAD;
		unique case (state_q)
			C_IDLE: begin
				cmd.latch = start;
			end
			C_DECODE: begin
				case (st.mode)
					OP_INSERT: begin
						if (st.full) begin
							cmd.emit = '{valid: 1'b1, kind: K_ERROR, err: E_FULL,
								src: SRC_REQ, last: 1'b1};
						end else begin
							cmd.insert     = 1'b1;
							cmd.scan_clear = 1'b1;
						end
					end
					OP_DELETE, OP_JOIN: begin
						if (st.empty || st.below_head) begin
							cmd.emit = '{valid: 1'b1, kind: K_DONE, err: E_NONE,
								src: SRC_ZERO, last: 1'b1};
						end else begin
							cmd.look_clear = 1'b1;
						end
					end
					OP_RETURN:   cmd.look_clear = 1'b1;
					OP_RETRIEVE: ;
					default: begin
						cmd.emit = '{valid: 1'b1, kind: K_DONE, err: E_NONE,
							src: SRC_ZERO, last: 1'b1};
					end
				endcase
			end
			C_LOOK: begin
				cmd.sel = SEL_LOOK;
				if (st.look_end) begin
					cmd.emit = '{valid: 1'b1, kind: K_ERROR, err: E_NOT_FOUND,
						src: SRC_REQ, last: 1'b1};
				end else if (st.look_hit) begin
					cmd.idx_cap = 1'b1;
				end else begin
					cmd.look_next = 1'b1;
				end
			end
			C_APPLY: begin
				cmd.sel = SEL_IDX;
				if (st.next_bad) begin
					cmd.emit = '{valid: 1'b1, kind: K_ERROR, err: E_STATE,
						src: SRC_REQ, last: 1'b1};
				end else begin
					cmd.apply = 1'b1;
					if (st.mode == OP_RETURN) begin
						cmd.push       = 1'b1;
						cmd.scan_clear = 1'b1;
					end else begin
						cmd.emit = '{valid: 1'b1, kind: K_DONE, err: E_NONE,
							src: SRC_ZERO, last: 1'b1};
					end
				end
			end
			C_SCAN: begin
				cmd.sel = SEL_DISP;
				if (st.scan_end || (st.disp_ok && st.free_empty)) begin
					cmd.emit = '{valid: 1'b1, kind: K_DONE, err: E_NONE,
						src: SRC_ZERO, last: 1'b1};
				end else if (st.disp_ok) begin
					cmd.dispatch = 1'b1;
					cmd.emit = '{valid: 1'b1, kind: K_DISPATCH, err: E_NONE,
						src: SRC_SLOT, last: 1'b0};
				end else begin
					cmd.skip = 1'b1;
				end
			end
			C_RET: begin
				if (!st.ret_ok) begin
					cmd.emit = '{valid: 1'b1, kind: K_DONE, err: E_NONE,
						src: SRC_ZERO, last: 1'b1};
				end else begin
					case (st.slot_state)
						JS_DEL: cmd.pop = 1'b1;
						JS_WAIT, JS_JOINED, JS_BUF: begin
							cmd.pop  = 1'b1;
							cmd.emit = '{valid: 1'b1, kind: K_RETRIEVED, err: E_NONE,
								src: SRC_SLOT, last: 1'b1};
						end
						JS_SENT, JS_SENT_DEL, JS_SENT_JOIN: begin
							cmd.emit = '{valid: 1'b1, kind: K_NOTREADY, err: E_NONE,
								src: SRC_SLOT, last: 1'b1};
						end
						default: begin
							cmd.emit = '{valid: 1'b1, kind: K_ERROR, err: E_STATE,
								src: SRC_REQ, last: 1'b1};
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != C_IDLE);

endmodule
`default_nettype wire

FILE: rtl/jdrt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job dispatch reorder table: datapath
// Job ring, free worker queue, configuration registers and result register.
// ----------------------------------------------------------------------------
module jdrt_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [jdrt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [jdrt_pkg::CFG_DATA_W-1:0] wr_data,
	input  wire logic [2:0]                      mode,
	input  wire logic [31:0]                     job_stamp,
	input  wire logic                            no_overlap,
	input  wire logic                            urgent,
	input  wire logic [31:0]                     now_time,
	input  wire jdrt_pkg::cmd_t                  cmd,
	output jdrt_pkg::status_t                    st,
	output logic                                 result_valid,
	output logic [2:0]                           kind,
	output logic [31:0]                          out_stamp,
	output logic [3:0]                           worker_id,
	output logic [1:0]                           entry_class,
	output logic [1:0]                           error_code,
	output logic                                 last
);
	import jdrt_pkg::*;

	// configuration
	logic [31:0]       start_tick_q;
	logic [WCNT_W-1:0] workers_q;
	logic [LIM_W-1:0]  limit_q;

	// request
	op_t                   mode_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  nov_q;
	logic                  urg_q;
	logic [31:0]           now_q;

	// job ring
	logic [STAMP_BITS-1:0] job_stamps_q  [JOB_SLOTS];
	job_state_t            job_states_q  [JOB_SLOTS];
	logic [WID_W-1:0]      job_workers_q [JOB_SLOTS];
	logic [SLOT_W-1:0]     head_q, tail_q, disp_q, idx_q;
	logic [FILL_W-1:0]     fill_q, look_q;
	logic [RES_W-1:0]      nres_q;

	// free worker queue
	logic [WID_W-1:0]  free_workers_q [MAX_WORKERS];
	logic [WID_W-1:0]  free_head_q, free_tail_q;
	logic [WCNT_W-1:0] free_fill_q;

	// result register
	kind_t                 kind_q;
	logic [STAMP_BITS-1:0] stamp_out_q;
	logic [WID_W-1:0]      wid_q;
	class_t                cls_q;
	err_t                  err_q;
	logic                  valid_q, last_q;

	logic [SLOT_W-1:0]     sel;
	logic [SLOT_W-1:0]     head_nx;
	logic [STAMP_BITS-1:0] slot_stamp;
	job_state_t            slot_state;
	job_state_t            next_state;
	logic [LIM_W-1:0]      lim_eff;
	logic [WCNT_W-1:0]     wrk_eff;
	logic [WCNT_W-1:0]     wr_workers;
	logic [WCNT_W-1:0]     wr_eff;
	class_t                slot_cls;

	always_comb begin
		if (limit_q == '0) lim_eff = LIM_W'(1);
		else if ({1'b0, limit_q} > (LIM_W+1)'(JOB_SLOTS - 1)) lim_eff = LIM_W'(JOB_SLOTS - 1);
		else lim_eff = limit_q;
	end

	assign wrk_eff    = (workers_q > WCNT_W'(MAX_WORKERS)) ? WCNT_W'(MAX_WORKERS) : workers_q;
	assign wr_workers = wr_data[WCNT_W-1:0];
	assign wr_eff     = (wr_workers > WCNT_W'(MAX_WORKERS)) ? WCNT_W'(MAX_WORKERS) : wr_workers;

	always_comb begin
		case (cmd.sel)
			SEL_HEAD: sel = head_q;
			SEL_LOOK: sel = head_q + look_q[SLOT_W-1:0];
			SEL_IDX:  sel = idx_q;
			SEL_DISP: sel = disp_q;
			default:  sel = head_q;
		endcase
	end

	assign slot_stamp = job_stamps_q[sel];
	assign slot_state = job_states_q[sel];
	assign head_nx    = head_q + SLOT_W'(1);

	always_comb begin
		next_state = JS_EMPTY;
		case (mode_q)
			OP_DELETE: begin
				case (slot_state)
					JS_WAIT, JS_JOINED, JS_BUF: next_state = JS_DEL;
					JS_SENT:                    next_state = JS_SENT_DEL;
					default:                    next_state = JS_EMPTY;
				endcase
			end
			OP_JOIN: begin
				case (slot_state)
					JS_WAIT, JS_BUF: next_state = JS_JOINED;
					JS_SENT:         next_state = JS_SENT_JOIN;
					default:         next_state = JS_EMPTY;
				endcase
			end
			OP_RETURN: begin
				case (slot_state)
					JS_SENT_JOIN: next_state = JS_JOINED;
					JS_SENT_DEL:  next_state = JS_DEL;
					JS_SENT:      next_state = JS_BUF;
					default:      next_state = JS_EMPTY;
				endcase
			end
			default: next_state = JS_EMPTY;
		endcase
	end

	always_comb begin
		case (slot_state)
			JS_JOINED: slot_cls = CLS_JOINED;
			JS_BUF:    slot_cls = CLS_BUF;
			default:   slot_cls = CLS_WAIT;
		endcase
	end

	always_comb begin
		st            = '0;
		st.mode       = mode_q;
		st.full       = fill_q >= FILL_W'(lim_eff);
		st.empty      = fill_q == '0;
		st.below_head = stamp_q < slot_stamp;
		st.look_end   = look_q == fill_q;
		st.look_hit   = slot_stamp == stamp_q;
		st.next_bad   = next_state == JS_EMPTY;
		st.scan_end   = (disp_q == tail_q) || (nres_q == RES_W'(MAX_RESULTS - 1));
		st.disp_ok    = (slot_state == JS_WAIT) && (wrk_eff != '0) && (now_q >= start_tick_q);
		st.free_empty = free_fill_q == '0;
		st.ret_ok     = (fill_q != '0) &&
			(urg_q || (now_q < start_tick_q) || (fill_q == FILL_W'(lim_eff)));
		st.slot_state = slot_state;
	end

	// configuration and request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_tick_q <= START_TICK_RST;
			workers_q    <= WORKERS_RST;
			limit_q      <= LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_TICK: start_tick_q <= wr_data[31:0];
				REG_WORKERS:    workers_q    <= wr_workers;
				REG_LIMIT:      limit_q      <= wr_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= op_t'(mode);
			stamp_q <= job_stamp[STAMP_BITS-1:0];
			nov_q   <= no_overlap;
			urg_q   <= urgent;
			now_q   <= now_time;
		end
	end

	// job ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOB_SLOTS; i++) job_states_q[i] <= JS_EMPTY;
			head_q <= '0;
			tail_q <= '0;
			disp_q <= '0;
			fill_q <= '0;
			look_q <= '0;
			nres_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.insert) begin
				job_states_q[tail_q] <= nov_q ? JS_JOINED : JS_WAIT;
				tail_q <= tail_q + SLOT_W'(1);
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.look_clear) look_q <= '0;
			if (cmd.look_next)  look_q <= look_q + FILL_W'(1);
			if (cmd.idx_cap)    idx_q  <= sel;
			if (cmd.apply)      job_states_q[idx_q] <= next_state;
			if (cmd.scan_clear) nres_q <= '0;
			if (cmd.dispatch) begin
				job_states_q[disp_q] <= JS_SENT;
				disp_q <= disp_q + SLOT_W'(1);
				nres_q <= nres_q + RES_W'(1);
			end
			if (cmd.skip) disp_q <= disp_q + SLOT_W'(1);
			if (cmd.pop) begin
				job_states_q[head_q] <= JS_EMPTY;
				if (disp_q == head_q) disp_q <= head_nx;
				head_q <= head_nx;
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			job_stamps_q[tail_q]  <= stamp_q;
			job_workers_q[tail_q] <= '0;
		end
		if (cmd.dispatch) job_workers_q[disp_q] <= free_workers_q[free_head_q];
	end

	// free worker queue; a worker count write refills it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORKERS; i++) free_workers_q[i] <= WID_W'(i);
			free_head_q <= '0;
			free_tail_q <= WORKERS_RST[WID_W-1:0];
			free_fill_q <= WORKERS_RST;
		end else if (wr_en && wr_index == REG_WORKERS) begin
			for (int i = 0; i < MAX_WORKERS; i++) free_workers_q[i] <= WID_W'(i);
			free_head_q <= '0;
			free_tail_q <= wr_eff[WID_W-1:0];
			free_fill_q <= wr_eff;
		end else begin
			if (cmd.dispatch) begin
				free_head_q <= free_head_q + WID_W'(1);
				free_fill_q <= free_fill_q - WCNT_W'(1);
			end
			// drop the returned worker if the queue already holds every worker
			if (cmd.push && free_fill_q < wrk_eff) begin
				free_workers_q[free_tail_q] <= job_workers_q[idx_q];
				free_tail_q <= free_tail_q + WID_W'(1);
				free_fill_q <= free_fill_q + WCNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= cmd.emit.valid;
			last_q  <= cmd.emit.valid & cmd.emit.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit.valid) begin
			kind_q <= cmd.emit.kind;
			err_q  <= cmd.emit.err;
			case (cmd.emit.src)
				SRC_REQ:  stamp_out_q <= stamp_q;
				SRC_SLOT: stamp_out_q <= slot_stamp;
				default:  stamp_out_q <= '0;
			endcase
			wid_q <= (cmd.emit.kind == K_DISPATCH) ? free_workers_q[free_head_q] : '0;
			cls_q <= (cmd.emit.kind == K_RETRIEVED) ? slot_cls : CLS_WAIT;
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign out_stamp    = 32'(stamp_out_q);
	assign worker_id    = 4'(wid_q);
	assign entry_class  = cls_q;
	assign error_code   = err_q;
	assign last         = last_q;

endmodule
`default_nettype wire

FILE: rtl/job_dispatch_reorder_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job dispatch reorder table: top level
// Ordered job ring with lifecycle states and a free worker FIFO.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Busy stays high until
// the command's last result is issued. Each result is shown with result_valid
// high for one cycle, and results cannot be stalled. Last marks the final
// result of a command.
// Command flow:
// - Retrieve of a live head: deleted heads are dropped, then the head is
//   retrieved or reported not ready.
// - Full-table insert, unknown mode, ignored delete or join: decode only.
// - Insert: decode, then a dispatch scan over S slots (S up to 15).
// - Delete and join: decode, a lookup to stamp position K (K up to 14), then
//   the state update.
// - Return: decode, lookup, state update, then the dispatch scan.
// - A stamp that is not found: the lookup walks all F jobs held.
// The lookup and the scan walk one job slot per cycle. A configuration write
// takes effect at the next edge. Issue configuration writes only while idle.
module job_dispatch_reorder_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] job_stamp,
	input  wire logic        no_overlap,
	input  wire logic        urgent,
	input  wire logic [31:0] now_time,
	output logic             result_valid,
	output logic [2:0]       kind,
	output logic [31:0]      out_stamp,
	output logic [3:0]       worker_id,
	output logic [1:0]       entry_class,
	output logic [1:0]       error_code,
	output logic             last
);
	import jdrt_pkg::*;

	cmd_t    cmd;
	status_t st;

	jdrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	jdrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.mode         (mode),
		.job_stamp    (job_stamp),
		.no_overlap   (no_overlap),
		.urgent       (urgent),
		.now_time     (now_time),
		.cmd          (cmd),
		.st           (st),
		.result_valid (result_valid),
		.kind         (kind),
		.out_stamp    (out_stamp),
		.worker_id    (worker_id),
		.entry_class  (entry_class),
		.error_code   (error_code),
		.last         (last)
	);

endmodule
`default_nettype wire

FILE: sim/tb_job_dispatch_reorder_table_top.sv
// ----------------------------------------------------------------------------
// Job dispatch reorder table: testbench
// Drives commands and register writes, predicts the result stream with a
// behavioral copy of the job ring and the free worker queue, and compares
// every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_job_dispatch_reorder_table_top;
	import jdrt_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] stamp;
		logic [3:0]  wid;
		logic [1:0]  cls;
		err_t        err;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [31:0] wr_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  mode = '0;
	logic [31:0] job_stamp = '0;
	logic        no_overlap = 1'b0;
	logic        urgent = 1'b0;
	logic [31:0] now_time = '0;
	logic        result_valid;
	logic [2:0]  kind;
	logic [31:0] out_stamp;
	logic [3:0]  worker_id;
	logic [1:0]  entry_class;
	logic [1:0]  error_code;
	logic        last;

	job_dispatch_reorder_table_top uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .start(start), .busy(busy), .mode(mode),
		.job_stamp(job_stamp), .no_overlap(no_overlap), .urgent(urgent),
		.now_time(now_time), .result_valid(result_valid), .kind(kind),
		.out_stamp(out_stamp), .worker_id(worker_id), .entry_class(entry_class),
		.error_code(error_code), .last(last)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0] cfg_tick;
	logic [4:0]  cfg_workers;
	logic [3:0]  cfg_limit;
	logic [31:0] p_stamps [JOB_SLOTS];
	job_state_t  p_states [JOB_SLOTS];
	logic [3:0]  p_workers [JOB_SLOTS];
	logic [3:0]  p_head, p_tail, p_disp;
	int          p_fill;
	logic [3:0]  p_free [MAX_WORKERS];
	logic [3:0]  p_fhead, p_ftail;
	int          p_ffill;

	result_t     expected_results[$];
	int          errors = 0;
	int          checked = 0;
	int          n_cmds = 0;
	int          n_dispatch = 0;
	int          n_retrieved = 0;
	longint      cycles = 0;
	bit          allow_gaps = 1'b1;

	function automatic int n_workers();
		return (cfg_workers > MAX_WORKERS) ? MAX_WORKERS : int'(cfg_workers);
	endfunction

	function automatic int job_cap();
		if (cfg_limit == 0) return 1;
		if (cfg_limit > JOB_SLOTS - 1) return JOB_SLOTS - 1;
		return int'(cfg_limit);
	endfunction

	function automatic void refill_workers();
		int n;
		n = n_workers();
		for (int i = 0; i < MAX_WORKERS; i++) p_free[i] = (i < n) ? 4'(i) : 4'd0;
		p_fhead = 0;
		p_ftail = 4'(n % MAX_WORKERS);
		p_ffill = n;
	endfunction

	function automatic void push_result(kind_t k, logic [31:0] s, logic [3:0] w,
	                                    logic [1:0] c, err_t e);
		result_t r;
		r.kind = k; r.stamp = s; r.wid = w; r.cls = c; r.err = e; r.last = 1'b0;
		expected_results.push_back(r);
		if (k == K_DISPATCH) n_dispatch++;
		if (k == K_RETRIEVED) n_retrieved++;
	endfunction

	function automatic bit find_job(logic [31:0] s, output logic [3:0] idx);
		logic [3:0] i;
		for (int k = 0; k < p_fill; k++) begin
			i = p_head + 4'(k);
			if (p_stamps[i] == s) begin
				idx = i;
				return 1'b1;
			end
		end
		idx = 0;
		return 1'b0;
	endfunction

	function automatic void dispatch_scan(logic [31:0] now, inout int n);
		while (p_disp != p_tail && n < MAX_RESULTS - 1) begin
			if (p_states[p_disp] == JS_WAIT && n_workers() > 0 && now >= cfg_tick) begin
				if (p_ffill == 0) return;
				p_workers[p_disp] = p_free[p_fhead];
				p_fhead++;
				p_ffill--;
				p_states[p_disp] = JS_SENT;
				push_result(K_DISPATCH, p_stamps[p_disp], p_workers[p_disp], 0, E_NONE);
				n++;
			end
			p_disp++;
		end
	endfunction

	function automatic void drop_head();
		p_states[p_head] = JS_EMPTY;
		if (p_disp == p_head) p_disp = p_head + 4'd1;
		p_head++;
		p_fill--;
	endfunction

	function automatic void predict_command(logic [2:0] m, logic [31:0] s, logic nov,
	                                        logic urg, logic [31:0] now);
		int n;
		logic [3:0] idx;
		job_state_t st, nx;
		n = 0;
		case (m)
			OP_INSERT: begin
				if (p_fill >= job_cap()) begin
					push_result(K_ERROR, s, 0, 0, E_FULL);
				end else begin
					p_stamps[p_tail] = s;
					p_states[p_tail] = nov ? JS_JOINED : JS_WAIT;
					p_workers[p_tail] = 0;
					p_tail++;
					p_fill++;
					dispatch_scan(now, n);
					push_result(K_DONE, 0, 0, 0, E_NONE);
				end
			end
			OP_DELETE, OP_JOIN: begin
				if (p_fill == 0 || s < p_stamps[p_head]) begin
					push_result(K_DONE, 0, 0, 0, E_NONE);
				end else if (!find_job(s, idx)) begin
					push_result(K_ERROR, s, 0, 0, E_NOT_FOUND);
				end else begin
					st = p_states[idx];
					if (m == OP_DELETE)
						nx = (st == JS_WAIT || st == JS_JOINED || st == JS_BUF) ? JS_DEL :
						     (st == JS_SENT) ? JS_SENT_DEL : JS_EMPTY;
					else
						nx = (st == JS_WAIT || st == JS_BUF) ? JS_JOINED :
						     (st == JS_SENT) ? JS_SENT_JOIN : JS_EMPTY;
					if (nx == JS_EMPTY) begin
						push_result(K_ERROR, s, 0, 0, E_STATE);
					end else begin
						p_states[idx] = nx;
						push_result(K_DONE, 0, 0, 0, E_NONE);
					end
				end
			end
			OP_RETURN: begin
				if (!find_job(s, idx)) begin
					push_result(K_ERROR, s, 0, 0, E_NOT_FOUND);
				end else begin
					st = p_states[idx];
					nx = (st == JS_SENT_JOIN) ? JS_JOINED : (st == JS_SENT_DEL) ? JS_DEL :
					     (st == JS_SENT) ? JS_BUF : JS_EMPTY;
					if (nx == JS_EMPTY) begin
						push_result(K_ERROR, s, 0, 0, E_STATE);
					end else begin
						p_states[idx] = nx;
						if (p_ffill < n_workers()) begin
							p_free[p_ftail] = p_workers[idx];
							p_ftail++;
							p_ffill++;
						end
						dispatch_scan(now, n);
						push_result(K_DONE, 0, 0, 0, E_NONE);
					end
				end
			end
			OP_RETRIEVE: begin
				forever begin
					if (!(p_fill > 0 && (urg || now < cfg_tick || p_fill == job_cap()))) begin
						push_result(K_DONE, 0, 0, 0, E_NONE);
						break;
					end
					st = p_states[p_head];
					if (st == JS_DEL) begin
						drop_head();
						continue;
					end
					if (st == JS_WAIT || st == JS_JOINED || st == JS_BUF) begin
						push_result(K_RETRIEVED, p_stamps[p_head], 0,
						            (st == JS_WAIT) ? CLS_WAIT :
						            (st == JS_JOINED) ? CLS_JOINED : CLS_BUF, E_NONE);
						drop_head();
					end else if (st == JS_SENT || st == JS_SENT_DEL || st == JS_SENT_JOIN) begin
						push_result(K_NOTREADY, p_stamps[p_head], 0, 0, E_NONE);
					end else begin
						push_result(K_ERROR, s, 0, 0, E_STATE);
					end
					break;
				end
			end
			default: push_result(K_DONE, 0, 0, 0, E_NONE);
		endcase
		expected_results[$].last = 1'b1;
	endfunction

	// random idle burst on the command side
	task automatic maybe_idle();
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// start stays high between back-to-back commands; busy blocks a second take
	task automatic send_cmd(logic [2:0] m, logic [31:0] s, logic nov, logic urg,
	                        logic [31:0] now);
		maybe_idle();
		start <= 1'b1;
		mode <= m;
		job_stamp <= s;
		no_overlap <= nov;
		urgent <= urg;
		now_time <= now;
		do @(posedge clk); while (busy);
		predict_command(m, s, nov, urg, now);
		n_cmds++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		wr_en <= 1'b1;
		wr_index <= r;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		case (r)
			REG_START_TICK: cfg_tick = v;
			REG_WORKERS: begin
				cfg_workers = v[4:0];
				refill_workers();
			end
			default: cfg_limit = v[3:0];
		endcase
		@(posedge clk);
	endtask

	// pick a stamp of a live job most of the time, else something random
	function automatic logic [31:0] pick_stamp();
		if (p_fill > 0 && $urandom_range(0, 9) < 8)
			return p_stamps[p_head + 4'($urandom_range(0, p_fill - 1))];
		return $urandom();
	endfunction

	logic [31:0] next_stamp = 32'd100;

	task automatic test_directed();
		send_cmd(OP_RETRIEVE, 0, 0, 1, 0);
		send_cmd(OP_DELETE, 5, 0, 0, 0);
		send_cmd(OP_RETURN, 7, 0, 0, 0);
		send_cmd(3'd5, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
		send_cmd(3'd7, 0, 0, 0, 0);
		send_cmd(OP_INSERT, 10, 0, 0, 0);
		send_cmd(OP_INSERT, 20, 1, 0, 100);
		send_cmd(OP_INSERT, 30, 0, 0, 100);
		send_cmd(OP_INSERT, 40, 0, 0, 100);
		send_cmd(OP_INSERT, 50, 0, 0, 100);
		send_cmd(OP_JOIN, 30, 0, 0, 100);
		send_cmd(OP_DELETE, 40, 0, 0, 100);
		send_cmd(OP_RETURN, 40, 0, 0, 100);
		send_cmd(OP_RETURN, 30, 0, 0, 100);
		send_cmd(OP_JOIN, 1, 0, 0, 100);
		send_cmd(OP_DELETE, 99, 0, 0, 100);
		send_cmd(OP_RETURN, 20, 0, 0, 100);
		send_cmd(OP_RETRIEVE, 0, 0, 0, 100);
		send_cmd(OP_RETRIEVE, 0, 0, 1, 100);
		send_cmd(OP_RETRIEVE, 0, 0, 1, 100);
		send_cmd(OP_INSERT, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
		send_cmd(OP_RETURN, 50, 0, 0, 32'hFFFF_FFFF);
		send_cmd(OP_RETRIEVE, 0, 0, 1, 100);
		send_cmd(OP_RETRIEVE, 0, 0, 1, 0);
		wait_idle();
	endtask

	// mostly well-formed traffic: growing stamps, returns of held jobs
	task automatic test_random(int count, int wmax);
		int r;
		logic [31:0] now;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			now = ($urandom_range(0, 7) == 0) ? $urandom() :
			      cfg_tick + 32'($urandom_range(0, 1000));
			if (r < 30) begin
				next_stamp += 32'($urandom_range(1, 50));
				send_cmd(OP_INSERT, ($urandom_range(0, 19) == 0) ? $urandom() : next_stamp,
				         $urandom_range(0, 4) == 0, 1'($urandom()), now);
			end else if (r < 55) begin
				send_cmd(OP_RETURN, pick_stamp(), 1'($urandom()), 1'($urandom()), now);
			end else if (r < 65) begin
				send_cmd(OP_DELETE, pick_stamp(), 1'($urandom()), 1'($urandom()), now);
			end else if (r < 75) begin
				send_cmd(OP_JOIN, pick_stamp(), 1'($urandom()), 1'($urandom()), now);
			end else if (r < 97) begin
				send_cmd(OP_RETRIEVE, $urandom(), 1'($urandom()),
				         $urandom_range(0, 2) != 0, now);
			end else begin
				send_cmd(3'($urandom_range(5, 7)), $urandom(), 1'($urandom()),
				         1'($urandom()), $urandom());
			end
		end
		wait_idle();
		if (wmax >= 0) write_reg(REG_WORKERS, 32'($urandom_range(0, wmax)));
	endtask

	task automatic test_configs();
		write_reg(REG_START_TICK, 0);
		write_reg(REG_WORKERS, 16);
		write_reg(REG_LIMIT, 15);
		test_random(80, 16);
		write_reg(REG_START_TICK, 32'hFFFF_FFFF);
		write_reg(REG_WORKERS, 31);
		write_reg(REG_LIMIT, 0);
		test_random(40, -1);
		write_reg(REG_START_TICK, 200);
		write_reg(REG_WORKERS, 0);
		write_reg(REG_LIMIT, 1);
		test_random(40, -1);
		write_reg(REG_START_TICK, 32'($urandom_range(0, 1000)));
		write_reg(REG_WORKERS, 2);
		write_reg(REG_LIMIT, 6);
		test_random(100, 5);
		write_reg(REG_LIMIT, 14);
		write_reg(REG_WORKERS, 16);
		write_reg(REG_START_TICK, 50);
		test_random(80, 16);
		allow_gaps = 1'b0;
		write_reg(REG_WORKERS, 4);
		test_random(80, -1);
	endtask

	// check each result transaction
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result kind %0d stamp %0h", kind, out_stamp);
			end else begin
				exp_r = expected_results.pop_front();
				checked++;
				if (kind !== exp_r.kind || out_stamp !== exp_r.stamp || worker_id !== exp_r.wid ||
				    entry_class !== exp_r.cls || error_code !== exp_r.err || last !== exp_r.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp k%0d s%0h w%0d c%0d e%0d l%0d, got k%0d s%0h w%0d c%0d e%0d l%0d",
						         exp_r.kind, exp_r.stamp, exp_r.wid, exp_r.cls, exp_r.err, exp_r.last,
						         kind, out_stamp, worker_id, entry_class, error_code, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		cfg_tick = START_TICK_RST;
		cfg_workers = 5'(WORKERS_RST);
		cfg_limit = LIMIT_RST;
		for (int i = 0; i < JOB_SLOTS; i++) begin
			p_stamps[i] = 0;
			p_states[i] = JS_EMPTY;
			p_workers[i] = 0;
		end
		p_head = 0; p_tail = 0; p_disp = 0; p_fill = 0;
		refill_workers();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_configs();
		if (expected_results.size() != 0) errors += expected_results.size();
		$display("%0d commands, %0d results checked (%0d dispatches, %0d retrievals)",
		         n_cmds, checked, n_dispatch, n_retrieved);
		if (errors == 0) $display("RESULT: OK");
		else begin
			$display("%0d failures", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
